FILE: rtl/npb_pkg.sv
// Shared types and constants for the nearest-point path blend block.
`timescale 1ns / 1ps
`default_nettype none
package npb_pkg;

	localparam int COORD_W   = 32;
	localparam int WEIGHT_W  = 17;
	localparam int NEAREST_W = 10;
	localparam int DIST_W    = 66;
	localparam int FRAC_W    = 16;

	// Request command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_BLEND  = 2'd2;

	// Starting minimum: above any reachable squared distance (at most 2^65)
	localparam logic [DIST_W-1:0] DIST_START = {DIST_W{1'b1}};

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_speed;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] blend_x;
		logic signed [COORD_W-1:0] blend_y;
		logic signed [COORD_W-1:0] max_speed;
		logic [NEAREST_W-1:0]      nearest_index;
		logic                      found;
	} res_t;

	// Distance unit status toward the sequencer
	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [DIST_W-1:0] sq_dist;
	} dist_out_t;

	// Blend unit operand and result
	typedef struct packed {
		logic                      valid;
		logic                      axis_y;
		logic signed [COORD_W-1:0] q;
		logic signed [COORD_W-1:0] r;
	} blend_in_t;

	typedef struct packed {
		logic                      valid;
		logic                      axis_y;
		logic signed [COORD_W-1:0] value;
	} blend_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_MUL_X,
		ST_MUL_Y,
		ST_BWAIT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/npb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module npb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/npb_dist.sv
// Pipelined squared-distance unit shared by every point of a scan.
`timescale 1ns / 1ps
`default_nettype none
module npb_dist #(
	parameter int IW = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic [IW-1:0]                     in_idx,
	input  wire logic signed [npb_pkg::COORD_W-1:0] ref_x,
	input  wire logic signed [npb_pkg::COORD_W-1:0] ref_y,
	input  wire logic signed [npb_pkg::COORD_W-1:0] qry_x,
	input  wire logic signed [npb_pkg::COORD_W-1:0] qry_y,
	output npb_pkg::dist_out_t                     out,
	output logic [IW-1:0]                          out_idx
);
	import npb_pkg::*;

	localparam int SQ_W = 2 * COORD_W;

	logic                  v_s2, v_s3, v_s4;
	logic [IW-1:0]         idx_s2, idx_s3, idx_s4;
	logic [COORD_W:0]      ax_s2, ay_s2;
	logic [2*COORD_W:0]    sx_s3, sy_s3;
	logic [DIST_W-1:0]     sum_s4;
	logic signed [COORD_W:0] dx, dy;

	// Exact 33-bit differences
	assign dx = {qry_x[COORD_W-1], qry_x} - {ref_x[COORD_W-1], ref_x};
	assign dy = {qry_y[COORD_W-1], qry_y} - {ref_y[COORD_W-1], ref_y};

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Magnitudes, squares, then sum
	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		ax_s2  <= dx[COORD_W] ? -dx : dx;
		ay_s2  <= dy[COORD_W] ? -dy : dy;

		idx_s3 <= idx_s2;
		// magnitude 2^32 squares to exactly 2^64
		sx_s3 <= ax_s2[COORD_W] ? {1'b1, {(2*COORD_W){1'b0}}}
		                        : {1'b0, SQ_W'(ax_s2[COORD_W-1:0]) * SQ_W'(ax_s2[COORD_W-1:0])};
		sy_s3 <= ay_s2[COORD_W] ? {1'b1, {(2*COORD_W){1'b0}}}
		                        : {1'b0, SQ_W'(ay_s2[COORD_W-1:0]) * SQ_W'(ay_s2[COORD_W-1:0])};

		idx_s4 <= idx_s3;
		sum_s4 <= {1'b0, sx_s3} + {1'b0, sy_s3};
	end

	assign out.valid   = v_s4;
	assign out.busy    = v_s2 | v_s3 | v_s4;
	assign out.sq_dist = sum_s4;
	assign out_idx     = idx_s4;

endmodule
`default_nettype wire

FILE: rtl/npb_blend.sv
// Two-stage blend unit: offset times weight, then floor shift, add and saturate.
`timescale 1ns / 1ps
`default_nettype none
module npb_blend (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire npb_pkg::blend_in_t           in,
	input  wire logic [npb_pkg::WEIGHT_W-1:0] weight,
	output npb_pkg::blend_out_t               out
);
	import npb_pkg::*;

	localparam int PROD_W = COORD_W + 1 + WEIGHT_W + 1;
	localparam int SH_W   = PROD_W - FRAC_W;

	logic signed [COORD_W:0]   diff;
	logic signed [PROD_W-1:0]  prod;
	logic                      v_s1, axis_s1, v_s2, axis_s2;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [COORD_W-1:0] q_s1, value_s2;
	logic signed [SH_W-1:0]    shifted, sum;
	logic signed [COORD_W-1:0] sat;

	assign diff = {in.r[COORD_W-1], in.r} - {in.q[COORD_W-1], in.q};
	assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));

	// Arithmetic shift floors the offset
	assign shifted = prod_s1[PROD_W-1:FRAC_W];
	assign sum     = {{(SH_W-COORD_W){q_s1[COORD_W-1]}}, q_s1} + shifted;

	// Clamp to the signed 32-bit range
	always_comb begin
		if (sum[SH_W-1:COORD_W-1] == '0 || sum[SH_W-1:COORD_W-1] == '1) begin
			sat = sum[COORD_W-1:0];
		end else if (sum[SH_W-1]) begin
			sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
		end
	end

	// Hold operands per stage
	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		q_s1     <= in.q;
		axis_s1  <= in.axis_y;
		value_s2 <= sat;
		axis_s2  <= axis_s1;
	end

	assign out.valid  = v_s2;
	assign out.axis_y = axis_s2;
	assign out.value  = value_s2;

endmodule
`default_nettype wire

FILE: rtl/nearest_point_path_blend.sv
// Top level: path store, scan sequencer, distance and blend units, result register.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Signals                         Direction  Content
// request   req_valid, req_stall, req_data  in         req_t: cmd, point_x/y, point_speed
// result    res_valid, res_stall, res_data  out        res_t: blend_x/y, max_speed, index, found
// config    cfg_we, cfg_wdata               in         blend_weight, Q1.16
//
// Clear and append leave the request channel free. A blend query stalls requests until its
// result is loaded: the scan streams one stored point per cycle out of the path RAM read port
// through the three-stage distance unit, then two passes through the blend multiplier. An
// empty path skips the scan and goes straight to the output state. arst_n clears the point
// count, the weight and all control; path contents are kept. A stalled result holds in the
// output register; clear and append still pass, the next answer waits for it.
//
module nearest_point_path_blend #(
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire npb_pkg::req_t                req_data,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output npb_pkg::res_t                     res_data,
	input  wire logic                         cfg_we,
	input  wire logic [npb_pkg::WEIGHT_W-1:0] cfg_wdata
);
	import npb_pkg::*;

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int RAM_W = 3 * COORD_W;

	state_t state_q, state_d;

	logic [WEIGHT_W-1:0]       weight_q;
	logic [CW-1:0]             count_q, last_w;
	logic [IW-1:0]             addr_q, best_idx_q, rd_addr, dist_idx;
	logic [DIST_W-1:0]         best_q;
	logic signed [COORD_W-1:0] qx_q, qy_q, qs_q, bx_q, by_q;
	logic                      found_q, v_s1_q;
	logic [IW-1:0]             idx_s1_q;
	logic                      res_valid_q;
	res_t                      res_q, res_next;
	logic                      accept, do_append, load_res;
	logic [RAM_W-1:0]          rdata;
	logic signed [COORD_W-1:0] ref_x, ref_y, ref_s;
	logic [IW+NEAREST_W-1:0]   idx_ext;
	dist_out_t                 dist_out;
	blend_in_t                 blend_in;
	blend_out_t                blend_out;

	assign accept    = req_valid && !req_stall;
	assign do_append = accept && req_data.cmd == CMD_APPEND && count_q < CW'(DEPTH);
	assign last_w    = count_q - CW'(1);
	assign {ref_s, ref_y, ref_x} = rdata;

	// Path store: {speed, y, x}
	npb_ram #(
		.WIDTH (RAM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_append),
		.waddr (count_q[IW-1:0]),
		.wdata ({req_data.point_speed, req_data.point_y, req_data.point_x}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	npb_dist #(
		.IW (IW)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1_q),
		.in_idx   (idx_s1_q),
		.ref_x    (ref_x),
		.ref_y    (ref_y),
		.qry_x    (qx_q),
		.qry_y    (qy_q),
		.out      (dist_out),
		.out_idx  (dist_idx)
	);

	npb_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (blend_in),
		.weight (weight_q),
		.out    (blend_out)
	);

	// Next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_addr   = best_idx_q;
		blend_in  = '{valid: 1'b0, axis_y: 1'b0, q: qx_q, r: ref_x};
		load_res  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req_data.cmd == CMD_BLEND) begin
					state_d = (count_q == '0) ? ST_OUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = addr_q;
				if (addr_q == last_w[IW-1:0]) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1_q && !dist_out.busy) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				blend_in.valid = 1'b1;
				state_d        = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				blend_in = '{valid: 1'b1, axis_y: 1'b1, q: qy_q, r: ref_y};
				state_d  = ST_BWAIT;
			end
			ST_BWAIT: begin
				if (blend_out.valid && blend_out.axis_y) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, point count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= '0;
			count_q     <= '0;
			v_s1_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				weight_q <= cfg_wdata;
			end
			if (accept && req_data.cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (do_append) begin
				count_q <= count_q + CW'(1);
			end
			v_s1_q <= (state_q == ST_SCAN);
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Query capture, address walk and running minimum
	always_ff @(posedge clk) begin
		idx_s1_q <= addr_q;
		if (accept && req_data.cmd == CMD_BLEND) begin
			qx_q    <= req_data.point_x;
			qy_q    <= req_data.point_y;
			qs_q    <= req_data.point_speed;
			found_q <= (count_q != '0);
			addr_q  <= '0;
			best_q  <= DIST_START;
			best_idx_q <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				addr_q <= addr_q + IW'(1);
			end
			// strict compare keeps the lowest index on a tie
			if (dist_out.valid && dist_out.sq_dist < best_q) begin
				best_q     <= dist_out.sq_dist;
				best_idx_q <= dist_idx;
			end
		end
		if (blend_out.valid && !blend_out.axis_y) begin
			bx_q <= blend_out.value;
		end
		if (blend_out.valid && blend_out.axis_y) begin
			by_q <= blend_out.value;
		end
		if (load_res) begin
			res_q <= res_next;
		end
	end

	// Result: blended point, or the query echoed for an empty path
	assign idx_ext = {{NEAREST_W{1'b0}}, best_idx_q};

	always_comb begin
		if (found_q) begin
			res_next.blend_x       = bx_q;
			res_next.blend_y       = by_q;
			res_next.max_speed     = (qs_q > ref_s) ? qs_q : ref_s;
			res_next.nearest_index = idx_ext[NEAREST_W-1:0];
			res_next.found         = 1'b1;
		end else begin
			res_next.blend_x       = qx_q;
			res_next.blend_y       = qy_q;
			res_next.max_speed     = qs_q;
			res_next.nearest_index = '0;
			res_next.found         = 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
`default_nettype wire

FILE: rtl/npb_checker.sv
// Port-level assertions for the nearest-point path blend block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module npb_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire npb_pkg::req_t req_data,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire npb_pkg::res_t res_data
);
	import npb_pkg::*;

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed or dropped");

	// Empty path reports index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.found |-> res_data.nearest_index == '0)
		else $error("nearest_index nonzero without a match");

	// Query request blocks the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.cmd == CMD_BLEND |=> req_stall)
		else $error("request taken while a query is in flight");

	// Clear and append leave the request channel free
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.cmd == CMD_CLEAR || req_data.cmd == CMD_APPEND)
		|=> !req_stall)
		else $error("path command held the request channel");

	// A new result appears only after a query was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_stall))
		else $error("result without a query");

endmodule

bind nearest_point_path_blend npb_checker u_npb_checker (.*);
`default_nettype wire

FILE: sim/tb_nearest_point_path_blend.sv
// Self-checking testbench for the nearest-point path blend block.
`timescale 1ns / 1ps
module tb_nearest_point_path_blend;
	import npb_pkg::*;

	localparam int DEPTH         = 1024;
	localparam int RANDOM_ITEMS  = 580;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 600_000;

	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [31:0] PMAX       = 32'h7fff_ffff;
	localparam logic [31:0] PMIN       = 32'h8000_0000;
	localparam longint      SAT_HI     = 64'sd2147483647;
	localparam longint      SAT_LO     = -64'sd2147483648;
	localparam res_t        NO_RESULT  = '0;

	typedef enum int {COORD_FULL, COORD_NEAR, COORD_GRID} coord_mode_t;

	// One directed step: optional weight write, the request, optional hand-typed result
	typedef struct packed {
		logic                set_w;
		logic [WEIGHT_W-1:0] w;
		req_t                req;
		logic                typed;
		res_t                exp;
	} step_t;

	localparam step_t DIRECTED_STEPS [24] = '{
		// empty path after reset: query echoed
		'{1'b0, 17'd0, '{CMD_BLEND, PMAX, PMIN, 32'h0001_0000},
			1'b1, '{PMAX, PMIN, 32'h0001_0000, 10'd0, 1'b0}},
		'{1'b0, 17'd0, '{CMD_BLEND, PMIN, PMAX, PMIN}, 1'b1, '{PMIN, PMAX, PMIN, 10'd0, 1'b0}},
		'{1'b0, 17'd0, '{CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
			1'b0, NO_RESULT},
		// single point, zero weight: query kept, speed is the larger
		'{1'b0, 17'd0, '{CMD_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0005_0000},
			1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_BLEND, 32'h0003_0000, 32'hffff_0000, 32'h0006_0000},
			1'b1, '{32'h0003_0000, 32'hffff_0000, 32'h0006_0000, 10'd0, 1'b1}},
		'{1'b0, 17'd0, '{CMD_APPEND, PMAX, PMAX, PMIN}, 1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_APPEND, PMIN, PMIN, PMAX}, 1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000},
			1'b0, NO_RESULT},
		// exact hit on a duplicated point: lowest index wins
		'{1'b0, 17'd0, '{CMD_BLEND, 32'h0001_0000, 32'h0002_0000, PMIN},
			1'b1, '{32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 10'd0, 1'b1}},
		// largest distances, tie between two corners
		'{1'b0, 17'd0, '{CMD_BLEND, PMIN, PMAX, 32'h0}, 1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_BLEND, PMAX, PMAX, PMAX}, 1'b1, '{PMAX, PMAX, PMAX, 10'd1, 1'b1}},
		// full weight: move onto the reference point
		'{1'b1, 17'd65536, '{CMD_BLEND, 32'h0, 32'h0, 32'h0},
			1'b1, '{32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 10'd0, 1'b1}},
		'{1'b0, 17'd0, '{CMD_BLEND, PMIN, PMIN, 32'hffff_ffff},
			1'b1, '{PMIN, PMIN, PMAX, 10'd2, 1'b1}},
		// half and smallest weight: rounding toward minus infinity
		'{1'b1, 17'd32768, '{CMD_BLEND, 32'h0000_1235, 32'hffff_fffb, 32'd7},
			1'b0, NO_RESULT},
		'{1'b1, 17'd1, '{CMD_BLEND, 32'hffff_0001, 32'h0000_0003, 32'h0}, 1'b0, NO_RESULT},
		// clear leaves an empty path
		'{1'b0, 17'd0, '{CMD_CLEAR, 32'h0, 32'h0, 32'h0}, 1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_BLEND, 32'h0000_1234, 32'hffff_fffb, 32'd7},
			1'b1, '{32'h0000_1234, 32'hffff_fffb, 32'd7, 10'd0, 1'b0}},
		'{1'b0, 17'd0, '{CMD_APPEND, 32'hffff_8000, 32'h0000_4000, 32'hffff_ffff},
			1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_APPEND, 32'h0000_8000, 32'h0000_4000, 32'd1}, 1'b0, NO_RESULT},
		'{1'b1, 17'd0, '{CMD_BLEND, 32'h0, 32'h0000_4000, 32'hffff_fffe},
			1'b1, '{32'h0, 32'h0000_4000, 32'hffff_ffff, 10'd0, 1'b1}},
		// weight above one: saturate both ways
		'{1'b0, 17'd0, '{CMD_CLEAR, 32'h0, 32'h0, 32'h0}, 1'b0, NO_RESULT},
		'{1'b0, 17'd0, '{CMD_APPEND, PMAX, PMIN, 32'd5}, 1'b0, NO_RESULT},
		'{1'b1, 17'h1_ffff, '{CMD_BLEND, PMIN, PMAX, 32'd6},
			1'b1, '{PMAX, PMIN, 32'd6, 10'd0, 1'b1}},
		'{1'b0, 17'd0, '{CMD_BLEND, 32'h0, 32'h0, PMIN}, 1'b0, NO_RESULT}
	};

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req_data  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res_data;
	logic                cfg_we    = 1'b0;
	logic [WEIGHT_W-1:0] cfg_wdata = '0;

	// Predictor state: the path, its length and the blend weight
	logic signed [31:0]  path_x   [DEPTH];
	logic signed [31:0]  path_y   [DEPTH];
	logic signed [31:0]  path_spd [DEPTH];
	int                  path_len = 0;
	logic [WEIGHT_W-1:0] weight_q = '0;

	res_t blend_results [$];
	int   mismatches = 0;
	int   gap_pct    = 0;
	int   stall_pct  = 0;
	int   stall_left = 0;

	nearest_point_path_blend #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none, else mostly short with a few long ones
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [65:0] squared_distance(input logic signed [31:0] ax, ay, bx, by);
		logic signed [32:0] dx, dy;
		logic [65:0]        mx, my;
		dx = 33'(ax) - 33'(bx);
		dy = 33'(ay) - 33'(by);
		mx = dx[32] ? 66'(-dx) : 66'(dx);
		my = dy[32] ? 66'(-dy) : 66'(dy);
		return mx * mx + my * my;
	endfunction

	// q + floor((r - q) * w / 2^16), clamped to 32 bits
	function automatic logic signed [31:0] scale_toward(input logic signed [31:0] q, r,
			input logic [WEIGHT_W-1:0] w);
		longint p, s;
		p = (longint'(r) - longint'(q)) * longint'(w);
		s = longint'(q) + (p >>> 16);
		if (s > SAT_HI)
			s = SAT_HI;
		if (s < SAT_LO)
			s = SAT_LO;
		return s[31:0];
	endfunction

	// Advance the path model by one request; return 1 with the result for a query
	function automatic logic predict_request(input req_t r, output res_t res);
		logic signed [31:0] qx, qy, qs, rs;
		logic [65:0]        best_dist, cand_dist;
		int                 best;
		qx = r.point_x;
		qy = r.point_y;
		qs = r.point_speed;
		res = '0;
		predict_request = 1'b0;
		case (r.cmd)
		CMD_CLEAR: path_len = 0;
		CMD_APPEND: begin
			if (path_len < DEPTH) begin
				path_x[path_len]   = qx;
				path_y[path_len]   = qy;
				path_spd[path_len] = qs;
				path_len++;
			end
		end
		CMD_BLEND: begin
			predict_request = 1'b1;
			if (path_len == 0) begin
				res.blend_x   = qx;
				res.blend_y   = qy;
				res.max_speed = qs;
			end else begin
				best_dist = '1;
				best = 0;
				for (int i = 0; i < path_len; i++) begin
					cand_dist = squared_distance(qx, qy, path_x[i], path_y[i]);
					if (cand_dist < best_dist) begin
						best_dist = cand_dist;
						best = i;
					end
				end
				rs = path_spd[best];
				res.blend_x       = scale_toward(qx, path_x[best], weight_q);
				res.blend_y       = scale_toward(qy, path_y[best], weight_q);
				res.max_speed     = (qs > rs) ? qs : rs;
				res.nearest_index = best[NEAREST_W-1:0];
				res.found         = 1'b1;
			end
		end
		default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord(input coord_mode_t mode);
		case (mode)
		COORD_NEAR: return $urandom_range(0, 'h3_ffff) - 'h2_0000;
		COORD_GRID: return ($urandom_range(0, 8) - 4) << 16;
		default:    return $urandom;
		endcase
	endfunction

	function automatic req_t point_request(input logic [1:0] cmd, input coord_mode_t mode);
		req_t r;
		r.cmd         = cmd;
		r.point_x     = rand_coord(mode);
		r.point_y     = rand_coord(mode);
		r.point_speed = $urandom_range(0, 1) ? $urandom : rand_coord(mode);
		return r;
	endfunction

	// Query at a random spot, or right on a stored point now and then
	function automatic req_t blend_request(input coord_mode_t mode);
		req_t r;
		int   idx;
		r = point_request(CMD_BLEND, mode);
		if (path_len != 0 && $urandom_range(0, 3) == 0) begin
			idx = $urandom_range(0, path_len - 1);
			r.point_x = path_x[idx];
			r.point_y = path_y[idx];
		end
		return r;
	endfunction

	// Hold the request until taken, then predict it
	task automatic send_request(input req_t r, input logic typed = 1'b0,
			input res_t typed_res = NO_RESULT);
		int   gap;
		res_t predicted;
		gap = pick_gap(gap_pct);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		if (predict_request(r, predicted))
			blend_results = {blend_results, (typed ? typed_res : predicted)};
	endtask

	// Write the weight once every query has answered and appends have settled
	task automatic write_blend_weight(input logic [WEIGHT_W-1:0] w);
		req_valid <= 1'b0;
		while (blend_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we   <= 1'b0;
		weight_q = w;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h got %h", $time, what, want, got);
	endtask

	task automatic compare_result(input res_t want, input res_t got);
		if (got.blend_x !== want.blend_x)
			flag_mismatch("blend_x", want.blend_x, got.blend_x);
		if (got.blend_y !== want.blend_y)
			flag_mismatch("blend_y", want.blend_y, got.blend_y);
		if (got.max_speed !== want.max_speed)
			flag_mismatch("max_speed", want.max_speed, got.max_speed);
		if (got.nearest_index !== want.nearest_index)
			flag_mismatch("nearest_index", want.nearest_index, got.nearest_index);
		if (got.found !== want.found)
			flag_mismatch("found", want.found, got.found);
	endtask

	// Check each taken result and stall the result channel at random
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid === 1'b1 && !res_stall) begin
				if (blend_results.size() == 0)
					flag_mismatch("unexpected result, blend_x", 'x, res_data.blend_x);
				else
					compare_result(blend_results.pop_front(), res_data);
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				stall_left = pick_gap(stall_pct);
				res_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		step_t               row;
		req_t                r;
		logic [WEIGHT_W-1:0] w;
		coord_mode_t         mode;
		int                  random_items, cap, pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps
		gap_pct   = 30;
		stall_pct = 30;
		foreach (DIRECTED_STEPS[k]) begin
			row = DIRECTED_STEPS[k];
			if (row.set_w)
				write_blend_weight(row.w);
			send_request(row.req, row.typed, row.exp);
		end

		// Random phases: new weight and pressure, usually a clear, then build and query a short path
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
			0:       w = '0;
			1:       w = 17'd65536;
			2:       w = '1;
			3:       w = WEIGHT_W'($urandom);
			default: w = WEIGHT_W'($urandom_range(0, 65536));
			endcase
			write_blend_weight(w);
			gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			mode = coord_mode_t'($urandom_range(0, 2));
			cap  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 128) : $urandom_range(1, 24);
			if ($urandom_range(0, 9) != 0) begin
				send_request(point_request(CMD_CLEAR, mode));
				random_items++;
			end
			repeat ($urandom_range(8, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 45 && path_len < cap)
					r = point_request(CMD_APPEND, mode);
				else if (pick < 92)
					r = blend_request(mode);
				else if (pick < 97)
					r = point_request(CMD_UNUSED, mode);
				else
					r = point_request(CMD_CLEAR, mode);
				send_request(r);
				if (r.cmd != CMD_UNUSED)
					random_items++;
			end
		end

		// Fill the path to the top, query along the way, then push past full
		write_blend_weight(WEIGHT_W'($urandom_range(0, 65536)));
		gap_pct   = 10;
		stall_pct = 10;
		send_request(point_request(CMD_CLEAR, COORD_FULL));
		for (int i = 0; i < DEPTH; i++) begin
			r = point_request(CMD_APPEND, (i % 2 != 0) ? COORD_GRID : COORD_FULL);
			if (i == DEPTH - 1) begin
				r.point_x = PMAX;
				r.point_y = PMAX;
			end
			send_request(r);
			if (i % 256 == 255)
				send_request(blend_request(COORD_GRID));
		end
		r = point_request(CMD_BLEND, COORD_FULL);
		r.point_x = PMAX;
		r.point_y = PMAX;
		send_request(r);
		repeat (6) begin
			r = point_request(CMD_APPEND, COORD_FULL);
			r.point_x = PMIN;
			r.point_y = PMIN;
			send_request(r);
		end
		r.cmd = CMD_BLEND;
		send_request(r);
		send_request(blend_request(COORD_FULL));

		// Drain and report
		req_valid <= 1'b0;
		while (blend_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
